/* src/trs_pkg.sv */
// ----------------------------------------------------------------------------
// trs_pkg: shared types and constants of the TLV record store
// Controller states, result codes, datapath command and status bundles.
// ----------------------------------------------------------------------------
package trs_pkg;

   // stored code byte of tag 0; tag t is stored as this plus t
   localparam logic [7:0] TAG_CODE_BASE = 8'h81;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_LEN,
      ST_DATA,
      ST_HDR_LEN,
      ST_HDR_VAL,
      ST_DONE
   } trs_state_type;

   typedef enum logic [2:0] {
      STS_WRITTEN     = 3'd0,
      STS_DROPPED     = 3'd1,
      STS_NO_SPACE    = 3'd2,
      STS_NOT_FOUND   = 3'd3,
      STS_READ_OK     = 3'd4,
      STS_READ_BEYOND = 3'd5
   } trs_status_type;

   // memory address source
   typedef enum logic [1:0] {
      ADR_CLEAR,
      ADR_FREE,
      ADR_LEN,
      ADR_DATA
   } trs_addr_sel_type;

   // memory write data source
   typedef enum logic [1:0] {
      WR_ZERO,
      WR_CODE,
      WR_LEN,
      WR_VALUE
   } trs_wdata_sel_type;

   typedef struct packed {
      logic              req_ready;
      logic              clear_step;
      logic              mem_en;
      logic              mem_we;
      trs_addr_sel_type  addr_sel;
      trs_wdata_sel_type wdata_sel;
      logic              create;
      logic              slen_cap;
      logic              res_load;
      trs_status_type    res_status;
      logic              out_load;
   } trs_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic clear_last;
      logic present;
      logic is_read;
      logic off_zero;
      logic fits;
      logic off_lt_len;
      logic len_zero;
      logic out_free;
   } trs_stat_type;

endpackage

/* src/trs_req_if.sv */
// ----------------------------------------------------------------------------
// trs_req_if: request channel of the TLV record store
// Valid/ready handshake carrying one byte read or write request.
// ----------------------------------------------------------------------------
interface trs_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [1:0] tag;
   logic [7:0] length;
   logic [7:0] offset;
   logic [7:0] value_byte;

   modport source (output valid, req_type, tag, length, offset, value_byte, input ready);
   modport sink   (input valid, req_type, tag, length, offset, value_byte, output ready);
endinterface

/* src/trs_rsp_if.sv */
// ----------------------------------------------------------------------------
// trs_rsp_if: response channel of the TLV record store
// Valid/ready handshake carrying one result per request.
// ----------------------------------------------------------------------------
interface trs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] data_byte;
   logic [7:0] stored_length;
   logic       record_created;

   modport source (output valid, status, data_byte, stored_length, record_created,
                   input ready);
   modport sink   (input valid, status, data_byte, stored_length, record_created,
                   output ready);
endinterface

/* src/trs_ctrl.sv */
// ----------------------------------------------------------------------------
// trs_ctrl: sequencing state machine of the TLV record store
// Walks each item through lookup, memory accesses and result hand-off.
// ----------------------------------------------------------------------------
module trs_ctrl
   import trs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  trs_stat_type stat,
   output trs_cmd_type  cmd
);

   trs_state_type state_ff;
   trs_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (stat.req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (stat.present) begin
               state_in = ST_LEN;
            end else if (stat.is_read || !stat.off_zero || !stat.fits) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_HDR_LEN;
            end
         end
         ST_LEN: begin
            if (stat.is_read && stat.off_lt_len) state_in = ST_DATA;
            else                                 state_in = ST_DONE;
         end
         ST_DATA: begin
            state_in = ST_DONE;
         end
         ST_HDR_LEN: begin
            if (stat.len_zero) state_in = ST_DONE;
            else               state_in = ST_HDR_VAL;
         end
         ST_HDR_VAL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.mem_en     = 1'b1;
            cmd.mem_we     = 1'b1;
            cmd.addr_sel   = ADR_CLEAR;
            cmd.wdata_sel  = WR_ZERO;
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
         end
         ST_LOOKUP: begin
            if (stat.present) begin
               cmd.mem_en   = 1'b1;
               cmd.addr_sel = ADR_LEN;
            end else if (stat.is_read || !stat.off_zero) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STS_NOT_FOUND;
            end else if (!stat.fits) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STS_NO_SPACE;
            end else begin
               cmd.create    = 1'b1;
               cmd.mem_en    = 1'b1;
               cmd.mem_we    = 1'b1;
               cmd.addr_sel  = ADR_FREE;
               cmd.wdata_sel = WR_CODE;
            end
         end
         ST_LEN: begin
            cmd.slen_cap = 1'b1;
            if (stat.is_read) begin
               if (stat.off_lt_len) begin
                  cmd.mem_en   = 1'b1;
                  cmd.addr_sel = ADR_DATA;
               end else begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = STS_READ_BEYOND;
               end
            end else begin
               cmd.res_load = 1'b1;
               if (stat.off_lt_len) begin
                  cmd.mem_en     = 1'b1;
                  cmd.mem_we     = 1'b1;
                  cmd.addr_sel   = ADR_DATA;
                  cmd.wdata_sel  = WR_VALUE;
                  cmd.res_status = STS_WRITTEN;
               end else begin
                  cmd.res_status = STS_DROPPED;
               end
            end
         end
         ST_DATA: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = STS_READ_OK;
         end
         ST_HDR_LEN: begin
            cmd.mem_en    = 1'b1;
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = ADR_LEN;
            cmd.wdata_sel = WR_LEN;
            if (stat.len_zero) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STS_DROPPED;
            end
         end
         ST_HDR_VAL: begin
            cmd.mem_en     = 1'b1;
            cmd.mem_we     = 1'b1;
            cmd.addr_sel   = ADR_DATA;
            cmd.wdata_sel  = WR_VALUE;
            cmd.res_load   = 1'b1;
            cmd.res_status = STS_WRITTEN;
         end
         ST_DONE: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // every reset restarts the memory clearing sweep
   a_reset_clears: assert property (@(posedge clock) reset |=> state_ff == ST_CLEAR)
      else $error("controller did not enter clearing sweep after reset");

endmodule

/* src/trs_datapath.sv */
// ----------------------------------------------------------------------------
// trs_datapath: byte memory, record registers and result registers
// Executes controller commands and reports lookup and compare status.
// ----------------------------------------------------------------------------
module trs_datapath
   import trs_pkg::*;
#(
   parameter int STORE_BYTES = 256
) (
   input  logic            clock,
   input  logic            reset,
   trs_req_if.sink         req_chan,
   trs_rsp_if.source       rsp_chan,
   input  trs_cmd_type     cmd,
   output trs_stat_type    stat
);

   localparam int AW   = $clog2(STORE_BYTES);
   localparam int FPW  = $clog2(STORE_BYTES + 1);
   localparam int SUMW = $clog2(STORE_BYTES + 258);

   logic [7:0]     store_mem [STORE_BYTES];

   // latched request
   logic           type_ff;
   logic [1:0]     tag_ff;
   logic [7:0]     len_ff;
   logic [7:0]     off_ff;
   logic [7:0]     vbyte_ff;

   // record bookkeeping
   logic [AW-1:0]  start_ff [4];
   logic [3:0]     start_vld_ff;
   logic [FPW-1:0] fp_ff;
   logic [AW-1:0]  clr_ff;
   logic           created_ff;

   logic [7:0]     rd_data_ff;
   logic [7:0]     slen_ff;

   // pending result
   trs_status_type res_status_ff;
   logic [7:0]     res_data_ff;
   logic [7:0]     res_slen_ff;
   logic           res_created_ff;

   // output register
   logic           out_valid_ff;
   trs_status_type out_status_ff;
   logic [7:0]     out_data_ff;
   logic [7:0]     out_slen_ff;
   logic           out_created_ff;

   logic           accept;
   logic           present;
   logic [AW-1:0]  start_addr;
   logic [AW-1:0]  data_addr;
   logic [AW-1:0]  mem_addr;
   logic [7:0]     mem_wdata;
   logic [SUMW-1:0] fit_sum;
   logic [7:0]     slen_val;

   assign accept     = req_chan.valid && cmd.req_ready;
   assign present    = start_vld_ff[tag_ff];
   assign start_addr = start_ff[tag_ff];
   assign data_addr  = start_addr + AW'(off_ff) + AW'(2);
   assign fit_sum    = SUMW'(fp_ff) + SUMW'(len_ff) + SUMW'(2);
   assign slen_val   = cmd.slen_cap ? rd_data_ff : slen_ff;

   always_comb begin
      unique case (cmd.addr_sel)
         ADR_CLEAR: mem_addr = clr_ff;
         ADR_FREE:  mem_addr = AW'(fp_ff);
         ADR_LEN:   mem_addr = start_addr + AW'(1);
         ADR_DATA:  mem_addr = data_addr;
         default:   mem_addr = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.wdata_sel)
         WR_ZERO:  mem_wdata = 8'h00;
         WR_CODE:  mem_wdata = TAG_CODE_BASE + {6'b0, tag_ff};
         WR_LEN:   mem_wdata = len_ff;
         WR_VALUE: mem_wdata = vbyte_ff;
         default:  mem_wdata = 8'h00;
      endcase
   end

   // single-port byte memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.mem_en) begin
         if (cmd.mem_we) begin
            store_mem[mem_addr] <= mem_wdata;
         end else begin
            rd_data_ff <= store_mem[mem_addr];
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         start_vld_ff <= '0;
         fp_ff        <= '0;
         clr_ff       <= '0;
         created_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + AW'(1);
         if (accept) created_ff <= 1'b0;
         if (cmd.create) begin
            start_vld_ff[tag_ff] <= 1'b1;
            fp_ff                <= FPW'(fit_sum);
            created_ff           <= 1'b1;
         end
         if (cmd.out_load)         out_valid_ff <= 1'b1;
         else if (rsp_chan.ready)  out_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff  <= req_chan.req_type;
         tag_ff   <= req_chan.tag;
         len_ff   <= req_chan.length;
         off_ff   <= req_chan.offset;
         vbyte_ff <= req_chan.value_byte;
      end
      if (cmd.create) start_ff[tag_ff] <= AW'(fp_ff);
      if (cmd.slen_cap) slen_ff <= rd_data_ff;
      if (cmd.res_load) begin
         res_status_ff  <= cmd.res_status;
         res_data_ff    <= (cmd.res_status == STS_READ_OK) ? rd_data_ff : 8'h00;
         res_slen_ff    <= created_ff ? len_ff : (present ? slen_val : 8'h00);
         res_created_ff <= created_ff;
      end
      if (cmd.out_load) begin
         out_status_ff  <= res_status_ff;
         out_data_ff    <= res_data_ff;
         out_slen_ff    <= res_slen_ff;
         out_created_ff <= res_created_ff;
      end
   end

   assign req_chan.ready          = cmd.req_ready;
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.status         = out_status_ff;
   assign rsp_chan.data_byte      = out_data_ff;
   assign rsp_chan.stored_length  = out_slen_ff;
   assign rsp_chan.record_created = out_created_ff;

   assign stat.req_valid  = req_chan.valid;
   assign stat.clear_last = (clr_ff == AW'(STORE_BYTES - 1));
   assign stat.present    = present;
   assign stat.is_read    = (type_ff == REQ_READ);
   assign stat.off_zero   = (off_ff == 8'h00);
   assign stat.fits       = (fit_sum <= SUMW'(STORE_BYTES));
   assign stat.off_lt_len = (off_ff < rd_data_ff);
   assign stat.len_zero   = (len_ff == 8'h00);
   assign stat.out_free   = !out_valid_ff || rsp_chan.ready;

   a_fp_in_range: assert property (@(posedge clock) disable iff (reset)
      fp_ff <= FPW'(STORE_BYTES))
      else $error("free pointer beyond store");

   a_created_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.record_created) |->
      (rsp_chan.status == STS_WRITTEN || rsp_chan.status == STS_DROPPED))
      else $error("record creation reported with wrong status");

   a_data_only_on_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != STS_READ_OK) |-> rsp_chan.data_byte == 8'h00)
      else $error("data byte nonzero outside a successful read");

endmodule

/* src/tlv_record_store_top.sv */
// ----------------------------------------------------------------------------
// tlv_record_store_top: tag-length-value record store, four tags
// Byte store of packed records (code, length, value bytes) with per-tag
// start registers; each item writes or reads at most one value byte.
// ----------------------------------------------------------------------------
//
//   channel    direction  handshake        payload
//   req_chan   in         valid / ready    req_type, tag, length, offset, value_byte
//   rsp_chan   out        valid / ready    status, data_byte, stored_length,
//                                          record_created
//
// Sequence: the single-port byte memory sets the steps of an item. For a
//   present tag the length byte is read first, then the value byte is read
//   or written; a missing tag or no space goes straight to the result; and a
//   new record needs header writes one byte per cycle.
// Reset: synchronous; afterwards a clearing sweep zeroes all STORE_BYTES bytes
//   of the store, one byte per cycle, with req_chan.ready low throughout.
// Stalls: the result sits in an output register, so the next item is taken
//   while the previous result waits on rsp_chan.ready.
//
module tlv_record_store_top
   import trs_pkg::*;
#(
   parameter int STORE_BYTES = 256
) (
   input  logic      clock,
   input  logic      reset,
   trs_req_if.sink   req_chan,
   trs_rsp_if.source rsp_chan
);

   trs_cmd_type  cmd;
   trs_stat_type stat;

   // sequencing: lookup, length read, value access, result hand-off
   trs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   // memory, record start registers, free pointer, result registers
   trs_datapath #(
      .STORE_BYTES (STORE_BYTES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule

/* verif/trs_result_checker.sv */
// ----------------------------------------------------------------------------
// trs_result_checker: result prediction and comparison for the record store
// Watches both channels. Each accepted request is run through a local copy of
// the store, and each accepted response is compared with the oldest
// prediction.
// ----------------------------------------------------------------------------
module trs_result_checker
   import trs_pkg::*;
#(
   parameter int STORE_BYTES = 256
) (
   input  logic clock,
   input  logic reset,
   trs_req_if   req_mon,
   trs_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      trs_status_type status;
      logic [7:0]     data_byte;
      logic [7:0]     stored_length;
      logic           record_created;
   } store_result_type;

   store_result_type result_q[$];

   // local image of the store
   logic [7:0] store_mem [STORE_BYTES];
   logic       tag_live [4];
   int         tag_base [4];
   int         free_ptr;

   function automatic store_result_type apply_access(logic kind, logic [1:0] tag,
                                                     logic [7:0] len, logic [7:0] off,
                                                     logic [7:0] val);
      store_result_type r;
      int base;
      int slen;
      r.status         = STS_NOT_FOUND;
      r.data_byte      = '0;
      r.record_created = 1'b0;
      base = tag_base[tag];
      slen = tag_live[tag] ? int'(store_mem[base + 1]) : 0;
      if (kind == REQ_READ) begin
         if (!tag_live[tag]) begin
            r.status = STS_NOT_FOUND;
         end else if (off < slen) begin
            r.data_byte = store_mem[base + 2 + off];
            r.status    = STS_READ_OK;
         end else begin
            r.status = STS_READ_BEYOND;
         end
      end else if (tag_live[tag]) begin
         // stored length wins; the requested one is ignored
         if (off < slen) begin
            store_mem[base + 2 + off] = val;
            r.status = STS_WRITTEN;
         end else begin
            r.status = STS_DROPPED;
         end
      end else if (off != 0) begin
         r.status = STS_NOT_FOUND;
      end else if (free_ptr + 2 + len > STORE_BYTES) begin
         r.status = STS_NO_SPACE;
      end else begin
         base                = free_ptr;
         store_mem[base]     = TAG_CODE_BASE + tag;
         store_mem[base + 1] = len;
         tag_live[tag]       = 1'b1;
         tag_base[tag]       = base;
         free_ptr            = base + 2 + len;
         slen                = len;
         r.record_created    = 1'b1;
         if (len != 0) begin
            store_mem[base + 2] = val;
            r.status = STS_WRITTEN;
         end else begin
            r.status = STS_DROPPED;
         end
      end
      r.stored_length = slen[7:0];
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      store_result_type want;
      if (reset) begin
         foreach (store_mem[i]) store_mem[i] = '0;
         foreach (tag_live[i]) begin
            tag_live[i] = 1'b0;
            tag_base[i] = 0;
         end
         free_ptr   = 0;
         fail_count = 0;
         result_q.delete();
      end else begin
         // compare before predicting, so a stray response is never masked
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (result_q.size() == 0) begin
               $error("response item with no request outstanding");
               fail_count++;
            end else begin
               want = result_q.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
                  fail_count++;
               end
               if (rsp_mon.data_byte !== want.data_byte) begin
                  $error("data_byte: expected %0d, got %0d",
                         want.data_byte, rsp_mon.data_byte);
                  fail_count++;
               end
               if (rsp_mon.stored_length !== want.stored_length) begin
                  $error("stored_length: expected %0d, got %0d",
                         want.stored_length, rsp_mon.stored_length);
                  fail_count++;
               end
               if (rsp_mon.record_created !== want.record_created) begin
                  $error("record_created: expected %0d, got %0d",
                         want.record_created, rsp_mon.record_created);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            result_q.push_back(apply_access(req_mon.req_type, req_mon.tag, req_mon.length,
                                            req_mon.offset, req_mon.value_byte));
         end
      end
      pending_results <= result_q.size();
   end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the TLV record store
// Directed accesses walk through record creation, the space limit and every
// status, then random reads and writes hit the four records under varying
// request gaps and response stalls. Checking lives in trs_result_checker.
// ----------------------------------------------------------------------------
module tb_top
   import trs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_BYTES = 256;

   logic clock;
   logic reset;
   logic rsp_take = 1'b0;   // receiver side ready, redrawn every cycle
   int   fail_count;
   int   pending_results;
   int   send_gap_pct;      // chance in 100 of a gap before an item
   int   rsp_stall_pct;     // chance in 100 of ready low on a cycle

   trs_req_if req_chan ();
   trs_rsp_if rsp_chan ();

   assign rsp_chan.ready = rsp_take;

   tlv_record_store_top #(
      .STORE_BYTES(STORE_BYTES)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   trs_result_checker #(
      .STORE_BYTES(STORE_BYTES)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: ready is redrawn each cycle. The result sits in an output
   // register, so stalls here back up into request acceptance too.
   always @(posedge clock) begin
      if (reset) begin
         rsp_take <= 1'b0;
      end else begin
         rsp_take <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Offer one item and hold it until accepted. Called just after a rising
   // edge; on return the item was taken at the current edge and valid is
   // still high, so the next call either keeps it high or drops it for a gap,
   // never both in one step.
   task automatic send_access(input logic kind, input logic [1:0] tag,
                              input logic [7:0] len, input logic [7:0] off,
                              input logic [7:0] val);
      if ($urandom_range(0, 99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= kind;
      req_chan.tag        <= tag;
      req_chan.length     <= len;
      req_chan.offset     <= off;
      req_chan.value_byte <= val;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Hold the request side off until every predicted result has come back.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   // Random access. All records hold at most 100 value bytes, so offsets
   // mostly stay near that and land on both sides of each stored length.
   task automatic random_access();
      logic [7:0] off;
      off = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 105))
                                         : 8'($urandom_range(0, 254));
      send_access($urandom_range(0, 1) ? REQ_READ : REQ_WRITE, 2'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)), off, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.req_type   <= REQ_WRITE;
      req_chan.tag        <= '0;
      req_chan.length     <= '0;
      req_chan.offset     <= '0;
      req_chan.value_byte <= '0;
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part; the clearing sweep after reset is absorbed by
      // the handshake wait of the first item
      // absent tag: read and nonzero-offset write both miss
      send_access(REQ_READ,  0, 8'd0,   8'd0,   8'd0);
      send_access(REQ_WRITE, 0, 8'd255, 8'd5,   8'h01);
      // a 255-byte value plus header can never fit
      send_access(REQ_WRITE, 0, 8'd255, 8'd0,   8'h01);
      // zero-length record: created, byte dropped; then nothing fits in it
      send_access(REQ_WRITE, 1, 8'd0,   8'd0,   8'h5A);
      send_access(REQ_WRITE, 1, 8'd9,   8'd0,   8'h5A);
      send_access(REQ_READ,  1, 8'd0,   8'd0,   8'd0);
      // 100-byte record at address 2; requested length ignored once present
      send_access(REQ_WRITE, 0, 8'd100, 8'd0,   8'hFF);
      send_access(REQ_WRITE, 0, 8'd7,   8'd99,  8'h00);
      send_access(REQ_WRITE, 0, 8'd7,   8'd100, 8'hAA);
      send_access(REQ_READ,  0, 8'd0,   8'd99,  8'd0);
      send_access(REQ_READ,  0, 8'd0,   8'd0,   8'd0);
      send_access(REQ_READ,  0, 8'd0,   8'd254, 8'd0);
      // never-written value byte reads back the cleared contents
      send_access(REQ_READ,  0, 8'd0,   8'd1,   8'd0);
      // free pointer at 104: 170 bytes too many, 100 fits
      send_access(REQ_WRITE, 2, 8'hAA,  8'd0,   8'hAA);
      send_access(REQ_WRITE, 2, 8'd100, 8'd0,   8'h3C);
      // free pointer at 206: one byte over the end, then exactly to the end
      send_access(REQ_WRITE, 3, 8'd49,  8'd0,   8'h11);
      send_access(REQ_WRITE, 3, 8'd48,  8'd1,   8'h11);
      send_access(REQ_WRITE, 3, 8'd48,  8'd0,   8'hC3);
      send_access(REQ_READ,  3, 8'd0,   8'd47,  8'd0);
      send_access(REQ_WRITE, 3, 8'd0,   8'd47,  8'hA5);
      send_access(REQ_READ,  3, 8'd0,   8'd47,  8'd0);
      send_access(REQ_READ,  3, 8'd0,   8'd48,  8'd0);
      send_access(REQ_WRITE, 2, 8'd0,   8'd254, 8'hFF);
      send_access(REQ_READ,  2, 8'd0,   8'd0,   8'd0);
      drain_results();

      // ---- random part: light sender gaps with heavy receiver stalls, then
      // the reverse, then full rate; each phase ends with a full drain
      send_gap_pct  = 14;
      rsp_stall_pct = 57;
      repeat (600) random_access();
      drain_results();

      send_gap_pct  = 57;
      rsp_stall_pct = 14;
      repeat (600) random_access();
      drain_results();

      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      repeat (600) random_access();
      drain_results();

      // leave room for a late stray result
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

/* tlv_record_store_top.f */
src/trs_pkg.sv
src/trs_req_if.sv
src/trs_rsp_if.sv
src/trs_ctrl.sv
src/trs_datapath.sv
src/tlv_record_store_top.sv
verif/trs_result_checker.sv
verif/tb_top.sv
